>>> rtl/mexp_pkg.sv
// shared constants for the modular exponentiation engine
// field widths, default parameter values and counter sizing; no dependencies
package mexp_pkg;

    // transaction field widths
    localparam int BASE_W  = 64;
    localparam int EXP_W   = 64;
    localparam int RES_W   = 32;
    localparam int CFG_W   = 32;
    localparam int S_DATA_W = BASE_W + EXP_W;

    // parameter defaults
    localparam int EXP_BITS_DEF = 64;
    localparam int MOD_BITS_DEF = 32;

    // step counter covers the base reduction, the longest pass
    localparam int CNT_W = $clog2(BASE_W);

endpackage

>>> rtl/modular_exponentiation_engine.sv
// Modular exponentiation engine: base ** exponent mod modulus, right-to-left binary.
// One shared bit-serial modular multiply/reduce unit under a small sequencer.
// Depends on mexp_pkg.
//
// Usage:
//   Write the modulus on the cfg channel (i_cfg_valid/i_cfg_data, o_cfg_ready is
//   always high) while the block is idle; a write whose low MOD_BITS bits are zero
//   is dropped. Reset leaves the modulus at 1.
//   s_axis carries one item per transaction: tdata = {exponent, base_value}.
//   m_axis returns one power_result per item in the low 32 bits of tdata.
// Throughput and sequencing:
//   One item at a time; s_axis_tready is high only while the sequencer is idle.
//   The base is reduced first, then each exponent bit up to the highest set one
//   takes a decision step and a bit-serial square (the highest is not squared);
//   a set bit adds a bit-serial multiply and one more decision step. A zero
//   exponent goes straight from the base reduction to the result decision.
// Reset and stalls:
//   Synchronous active-low reset empties the output register and returns to idle.
//   A result waits in the output register; the sequencer holds the next one there.
module modular_exponentiation_engine #(
    parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEF,
    parameter int MOD_BITS = mexp_pkg::MOD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mexp_pkg::CFG_W-1:0]    i_cfg_data,
    // input items
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [mexp_pkg::S_DATA_W-1:0] s_axis_tdata,   // base_value[63:0], exponent[127:64]
    // results
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [mexp_pkg::RES_W-1:0]    m_axis_tdata    // power_result[31:0]
);

    localparam int BASE_W = mexp_pkg::BASE_W;
    localparam int CNT_W  = mexp_pkg::CNT_W;
    localparam int U_W    = MOD_BITS + 2;

    // sequencer codes
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RED  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_SQR  = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [BASE_W-1:0]   r_shf, n_shf;
    logic [MOD_BITS-1:0] r_part, n_part;
    logic [MOD_BITS-1:0] r_sq, n_sq;
    logic [MOD_BITS-1:0] r_acc, n_acc;
    logic [EXP_BITS-1:0] r_exp, n_exp;
    logic [MOD_BITS-1:0] r_mod;
    logic                r_ovld, n_ovld;
    logic [MOD_BITS-1:0] r_res, n_res;

    logic [MOD_BITS-1:0] addend;
    logic [U_W-1:0]      u_sum, u_m1, u_m2, u_d1, u_d2;
    logic [MOD_BITS-1:0] u_out;
    logic                out_free;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = mexp_pkg::RES_W'(r_res);
    assign out_free      = !r_ovld || m_axis_tready;

    // shared unit: (2 * part + addend) mod modulus, addend never above modulus
    always_comb begin
        if (r_state == S_RED) begin
            addend = MOD_BITS'(r_shf[BASE_W-1]);
        end else begin
            addend = r_shf[BASE_W-1] ? r_sq : '0;
        end
        u_sum = {1'b0, r_part, 1'b0} + U_W'(addend);
        u_m1  = U_W'(r_mod);
        u_m2  = {1'b0, r_mod, 1'b0};
        u_d1  = u_sum - u_m1;
        u_d2  = u_sum - u_m2;
        if (u_sum >= u_m2) begin
            u_out = u_d2[MOD_BITS-1:0];
        end else if (u_sum >= u_m1) begin
            u_out = u_d1[MOD_BITS-1:0];
        end else begin
            u_out = u_sum[MOD_BITS-1:0];
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_shf   = r_shf;
        n_part  = r_part;
        n_sq    = r_sq;
        n_acc   = r_acc;
        n_exp   = r_exp;
        n_ovld  = r_ovld;
        n_res   = r_res;
        if (r_ovld && m_axis_tready) begin
            n_ovld = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_shf   = s_axis_tdata[BASE_W-1:0];
                    n_exp   = s_axis_tdata[BASE_W +: EXP_BITS];
                    n_part  = '0;
                    n_acc   = MOD_BITS'(1);
                    n_cnt   = CNT_W'(BASE_W - 1);
                    n_state = S_RED;
                end
            end
            S_RED: begin
                n_part = u_out;
                n_shf  = {r_shf[BASE_W-2:0], 1'b0};
                n_cnt  = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_sq    = u_out;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_part = '0;
                n_cnt  = CNT_W'(MOD_BITS - 1);
                if (r_exp == '0) begin
                    // no set bit left: hand over the result
                    if (out_free) begin
                        n_res   = r_acc;
                        n_ovld  = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (r_exp[0]) begin
                    n_shf    = {r_acc, (BASE_W - MOD_BITS)'(0)};
                    n_exp[0] = 1'b0;
                    n_state  = S_MUL;
                end else begin
                    n_shf   = {r_sq, (BASE_W - MOD_BITS)'(0)};
                    n_exp   = r_exp >> 1;
                    n_state = S_SQR;
                end
            end
            S_MUL: begin
                n_part = u_out;
                n_shf  = {r_shf[BASE_W-2:0], 1'b0};
                n_cnt  = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_acc   = u_out;
                    n_state = S_CHK;
                end
            end
            S_SQR: begin
                n_part = u_out;
                n_shf  = {r_shf[BASE_W-2:0], 1'b0};
                n_cnt  = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_sq    = u_out;
                    n_state = S_CHK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld  <= 1'b0;
            r_mod   <= MOD_BITS'(1);
        end else begin
            r_state <= n_state;
            r_ovld  <= n_ovld;
            // zero modulus writes are dropped
            if (i_cfg_valid && (i_cfg_data[MOD_BITS-1:0] != '0)) begin
                r_mod <= i_cfg_data[MOD_BITS-1:0];
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_shf  <= n_shf;
        r_part <= n_part;
        r_sq   <= n_sq;
        r_acc  <= n_acc;
        r_exp  <= n_exp;
        r_res  <= n_res;
    end

endmodule

>>> sim/modular_exponentiation_engine_test.sv
`timescale 1ns / 100ps
// self-checking testbench for the modular exponentiation engine
// drives modulus writes and base/exponent transactions, predicts every power result
// depends on mexp_pkg and rtl/modular_exponentiation_engine.sv
module modular_exponentiation_engine_test;

    // worst case per item at the default parameters
    localparam int MAX_LATENCY = 64 + mexp_pkg::EXP_BITS_DEF * (2 * mexp_pkg::MOD_BITS_DEF + 2)
                                 - mexp_pkg::MOD_BITS_DEF + 1;
    localparam int QUIET_LIMIT = 5 * MAX_LATENCY;
    localparam int ITEMS_PER_PHASE = 34;

    // expected power results in arrival order, with a private modulus copy
    class power_tracker;
        bit [mexp_pkg::RES_W-1:0] expected_powers[$];
        bit [mexp_pkg::CFG_W-1:0] modulus;
        int                       failures;
        int                       items_seen;
        int                       results_seen;

        function new();
            modulus      = mexp_pkg::CFG_W'(1);
            failures     = 0;
            items_seen   = 0;
            results_seen = 0;
        endfunction

        // a write of zero in the used bits leaves the modulus alone
        function void write_modulus(bit [mexp_pkg::CFG_W-1:0] value);
            bit [mexp_pkg::CFG_W-1:0] used;
            used = value & mexp_pkg::CFG_W'((64'd1 << mexp_pkg::MOD_BITS_DEF) - 64'd1);
            if (used != 0)
                modulus = used;
        endfunction

        // right-to-left square and multiply, all products below 2^64
        function bit [mexp_pkg::RES_W-1:0] raise_mod(bit [mexp_pkg::BASE_W-1:0] b,
                                                     bit [mexp_pkg::EXP_W-1:0] e);
            bit [63:0] m;
            bit [63:0] sq;
            bit [63:0] acc;
            m   = {32'd0, modulus};
            sq  = b % m;
            acc = 64'd1;
            for (int i = 0; i < mexp_pkg::EXP_BITS_DEF; i++) begin
                if (e[i])
                    acc = ((acc % m) * sq) % m;
                sq = (sq * sq) % m;
            end
            return acc[mexp_pkg::RES_W-1:0];
        endfunction

        function void note_item(bit [mexp_pkg::BASE_W-1:0] b, bit [mexp_pkg::EXP_W-1:0] e);
            expected_powers.push_back(raise_mod(b, e));
            items_seen++;
        endfunction

        function void check_result(bit [mexp_pkg::RES_W-1:0] actual);
            bit [mexp_pkg::RES_W-1:0] want;
            results_seen++;
            if (expected_powers.size() == 0) begin
                $error("power_result unexpected: expected none, actual %h", actual);
                failures++;
            end else begin
                want = expected_powers.pop_front();
                if (want !== actual) begin
                    $error("power_result mismatch: expected %h, actual %h", want, actual);
                    failures++;
                end
            end
        endfunction
    endclass

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_cfg_valid   = 1'b0;
    logic                          o_cfg_ready;
    logic [mexp_pkg::CFG_W-1:0]    i_cfg_data    = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [mexp_pkg::S_DATA_W-1:0] s_axis_tdata  = '0;   // base_value[63:0], exponent[127:64]
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [mexp_pkg::RES_W-1:0]    m_axis_tdata;         // power_result[31:0]

    power_tracker powers = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;
    int moduli_written = 0;

    modular_exponentiation_engine #(
        .EXP_BITS(mexp_pkg::EXP_BITS_DEF),
        .MOD_BITS(mexp_pkg::MOD_BITS_DEF)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // result side: check each transaction, then pick the next ready level
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            powers.check_result(m_axis_tdata);
        m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("no transaction for %0d cycles", quiet_cycles);
                $display("modular_exponentiation_engine test failed");
                $finish;
            end
        end
    end

    // one input transaction, with optional idle cycles before it
    task automatic send_item(input bit [mexp_pkg::BASE_W-1:0] b,
                             input bit [mexp_pkg::EXP_W-1:0] e);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {e, b};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        powers.note_item(b, e);
    endtask

    // hold the sender until every outstanding result has been taken
    task automatic wait_all_results();
        if (s_axis_tvalid)
            s_axis_tvalid <= 1'b0;
        while (powers.expected_powers.size() != 0)
            @(posedge i_clk);
    endtask

    // modulus write, only issued while the block is idle
    task automatic write_modulus(input bit [mexp_pkg::CFG_W-1:0] value);
        wait_all_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        powers.write_modulus(value);
        moduli_written++;
        i_cfg_valid <= 1'b0;
    endtask

    // random items: exponents mostly short, a quarter up to the full width
    task automatic run_phase(input int n_items);
        bit [mexp_pkg::BASE_W-1:0] b;
        bit [mexp_pkg::EXP_W-1:0]  e;
        bit [63:0]                 k;
        int                        len;
        for (int n = 0; n < n_items; n++) begin
            if ($urandom_range(3) == 0)
                len = $urandom_range(64, 25);
            else
                len = $urandom_range(24, 0);
            e = {$urandom, $urandom};
            if (len < 64)
                e &= (64'd1 << len) - 64'd1;
            if (len > 0 && $urandom_range(1))
                e[len-1] = 1'b1;
            k = {$urandom, $urandom};
            case ($urandom_range(4))
                0:       b = 64'($urandom_range(15));
                1:       b = 64'(k[31:0]) * 64'(powers.modulus) + 64'($urandom_range(3));
                2:       b = {32'd0, powers.modulus} - 64'd1;
                3:       b = '1;
                default: b = k;
            endcase
            send_item(b, e);
        end
    endtask

    // stimulus
    initial begin
        bit [mexp_pkg::CFG_W-1:0] m;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset modulus of one: zero exponent still gives one
        send_item(64'd5, 64'd0);
        send_item(64'd5, 64'd3);
        send_item(64'd0, 64'd0);

        // widest modulus, field extremes
        write_modulus('1);
        send_item('1, '1);
        send_item(64'd0, 64'd5);
        send_item(64'd0, 64'd0);
        send_item('1, 64'd1);
        send_item(64'hFFFF_FFFE, 64'd2);
        send_item(64'd1, '1);

        // zero write must be dropped
        write_modulus('0);
        send_item(64'd3, 64'd10);
        send_item(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);

        // smallest useful modulus
        write_modulus(32'd2);
        send_item(64'd3, '1);
        send_item(64'd4, 64'd1);

        // large prime moduli, fermat style exponents
        write_modulus(32'hFFFF_FFFB);
        send_item(64'd2, 64'h8000_0000_0000_0000);
        send_item(64'd12345, 64'hFFFF_FFFA);
        write_modulus(32'd1000000007);
        send_item(64'd2, 64'd1000000006);
        send_item(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);

        // random phases over idling patterns and moduli
        for (int p = 0; p < 8; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            case (p)
                0:       m = {1'b1, 31'($urandom)};
                1:       m = $urandom_range(255, 2);
                2:       m = '1;
                3:       m = 32'd1;
                4:       m = $urandom | 32'd1;
                5:       m = 32'h8000_0000;
                6:       m = $urandom_range(65535, 1);
                default: m = 32'hFFFF_FFFB;
            endcase
            write_modulus(m);
            run_phase(ITEMS_PER_PHASE);
        end

        // drain, then allow for any stray result
        wait_all_results();
        repeat (MAX_LATENCY) @(posedge i_clk);
        if (powers.expected_powers.size() != 0) begin
            $error("power_result missing: expected %0d more, actual 0",
                   powers.expected_powers.size());
            powers.failures++;
        end

        $display("%0d items sent and %0d results checked across %0d modulus writes,",
                 powers.items_seen, powers.results_seen, moduli_written);
        $display("with free running, sender idle, receiver stall and mixed phases");
        if (powers.failures == 0) begin
            $display("modular_exponentiation_engine test passed");
        end else begin
            $display("modular_exponentiation_engine test failed");
        end
        $finish;
    end
endmodule

>>> files.f
rtl/mexp_pkg.sv
rtl/modular_exponentiation_engine.sv
sim/modular_exponentiation_engine_test.sv
